[src/keydb_pkg.sv]
// Shared types and constants for the key debounce and hold detect block.
`default_nettype none
package keydb_pkg;

	// Widths of the fields and registers
	localparam int unsigned TickW     = 16;
	localparam int unsigned KeyW      = 2;
	localparam int unsigned CfgIndexW = 2;
	localparam int unsigned TdataW    = 8;

	localparam logic [TickW-1:0] ElapsedMax       = '1;
	localparam logic [TickW-1:0] DebounceTicksRst = TickW'(50);
	localparam logic [TickW-1:0] HoldTicksRst     = TickW'(1000);
	localparam logic [KeyW-1:0]  KeyNone          = '0;

	// Configuration register indexes
	localparam logic [CfgIndexW-1:0] CFG_DEBOUNCE_TICKS = CfgIndexW'(0);
	localparam logic [CfgIndexW-1:0] CFG_HOLD_TICKS     = CfgIndexW'(1);

	// Key phase
	typedef enum logic [1:0] {
		PH_DEBOUNCE = 2'd0,
		PH_PRESSED  = 2'd1,
		PH_HELD     = 2'd2
	} phase_t;

	// One input sample
	typedef struct packed {
		logic tick;
		logic stat_pressed;
		logic mode_pressed;
	} sample_t;

	// Timing settings
	typedef struct packed {
		logic [TickW-1:0] debounce_ticks;
		logic [TickW-1:0] hold_ticks;
	} cfg_t;

endpackage
`default_nettype wire

[src/keydb_cfg.sv]
// Configuration registers for the debounce and hold thresholds.
`default_nettype none
module keydb_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	input  wire logic [keydb_pkg::CfgIndexW-1:0] cfg_index,
	input  wire logic [keydb_pkg::TickW-1:0]     cfg_data,
	output keydb_pkg::cfg_t                     cfg_q
);

	// Decode the index; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks <= keydb_pkg::DebounceTicksRst;
			cfg_q.hold_ticks     <= keydb_pkg::HoldTicksRst;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				keydb_pkg::CFG_DEBOUNCE_TICKS: cfg_q.debounce_ticks <= cfg_data;
				keydb_pkg::CFG_HOLD_TICKS:     cfg_q.hold_ticks     <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

[src/keydb_in_stage.sv]
// Input register stage holding one sample item.
`default_nettype none
module keydb_in_stage (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [2:0]         sample_in,
	input  wire logic               advance,
	output logic                    valid_s1,
	output keydb_pkg::sample_t      sample_s1
);

	// Take a new item whenever the stage is empty or drains this cycle
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Payload needs no reset
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			sample_s1 <= keydb_pkg::sample_t'(sample_in);
		end
	end

endmodule
`default_nettype wire

[src/keydb_core.sv]
// Debounce and hold state machine with the result register.
`default_nettype none
module keydb_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire keydb_pkg::cfg_t            cfg,
	input  wire logic                       valid_s1,
	input  wire keydb_pkg::sample_t         sample_s1,
	output logic                            advance,
	output logic                            out_valid_q,
	input  wire logic                       out_ready,
	output logic [keydb_pkg::KeyW-1:0]      key_code_q,
	output logic                            is_hold_q
);

	logic [keydb_pkg::KeyW-1:0]  last_keys_q;
	keydb_pkg::phase_t           phase_q;
	logic [keydb_pkg::TickW-1:0] elapsed_q;

	logic [keydb_pkg::KeyW-1:0]  keys;
	logic                        same;
	logic [keydb_pkg::TickW-1:0] elapsed_inc;
	logic                        deb_done;
	logic                        hold_done;
	keydb_pkg::phase_t           phase_d;
	logic [keydb_pkg::TickW-1:0] elapsed_d;
	logic [keydb_pkg::KeyW-1:0]  msg_keys;
	logic                        msg_hold;
	logic                        take;

	// Result register drains or is empty
	assign advance = !out_valid_q || out_ready;
	assign take    = advance && valid_s1;

	assign keys = {sample_s1.stat_pressed, sample_s1.mode_pressed};
	assign same = (keys == last_keys_q);

	// Saturating tick count
	assign elapsed_inc = (sample_s1.tick && (elapsed_q != keydb_pkg::ElapsedMax))
		? elapsed_q + keydb_pkg::TickW'(1) : elapsed_q;
	assign deb_done  = (elapsed_inc >= cfg.debounce_ticks);
	assign hold_done = (elapsed_inc >= cfg.hold_ticks);

	// Next phase and counter
	always_comb begin
		phase_d   = phase_q;
		elapsed_d = elapsed_inc;
		if (!same) begin
			phase_d   = keydb_pkg::PH_DEBOUNCE;
			elapsed_d = '0;
		end else if (keys != keydb_pkg::KeyNone) begin
			unique case (phase_q)
				keydb_pkg::PH_DEBOUNCE: begin
					if (deb_done) begin
						phase_d   = keydb_pkg::PH_PRESSED;
						elapsed_d = '0;
					end
				end
				keydb_pkg::PH_PRESSED: begin
					if (hold_done) begin
						phase_d = keydb_pkg::PH_HELD;
					end
				end
				default: ;
			endcase
		end
	end

	// Message for this item
	always_comb begin
		msg_keys = keydb_pkg::KeyNone;
		msg_hold = 1'b0;
		if (same && (keys != keydb_pkg::KeyNone)) begin
			unique case (phase_q)
				keydb_pkg::PH_DEBOUNCE: begin
					if (deb_done) begin
						msg_keys = keys;
					end
				end
				keydb_pkg::PH_PRESSED: begin
					if (hold_done) begin
						msg_keys = keys;
						msg_hold = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// State updates once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_keys_q <= keydb_pkg::KeyNone;
			phase_q     <= keydb_pkg::PH_DEBOUNCE;
			elapsed_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (take) begin
				last_keys_q <= keys;
				phase_q     <= phase_d;
				elapsed_q   <= elapsed_d;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (take) begin
			key_code_q <= msg_keys;
			is_hold_q  <= msg_hold;
		end
	end

endmodule
`default_nettype wire

[src/key_debounce_hold_detect.sv]
// An accepted sample item passes the input stage register, then the result register.
// Throughput: one item per cycle unless m_tready stalls; phase/counter update and
// result register are both handled in the single cycle the item leaves the input stage.
// Reset (arst_n low, asynchronous): no key, debounce phase, counter zero,
// thresholds 50 and 1000 ticks, both stages empty.
`default_nettype none
module key_debounce_hold_detect (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Sample items
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [keydb_pkg::TdataW-1:0]    s_tdata,  // [0] mode_pressed, [1] stat_pressed, [2] tick, rest zero
	// Result items
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [keydb_pkg::TdataW-1:0]         m_tdata,  // [1:0] key_code, rest zero
	output logic                                 m_tuser,  // [0] is_hold
	// Configuration writes
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [keydb_pkg::CfgIndexW-1:0] cfg_index,
	input  wire logic [keydb_pkg::TickW-1:0]     cfg_data
);

	keydb_pkg::cfg_t            cfg;
	keydb_pkg::sample_t         sample_s1;
	logic                       valid_s1;
	logic                       advance;
	logic [keydb_pkg::KeyW-1:0] key_code;

	assign cfg_ready = 1'b1;

	keydb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_q     (cfg)
	);

	keydb_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.sample_in (s_tdata[2:0]),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.sample_s1 (sample_s1)
	);

	keydb_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.valid_s1    (valid_s1),
		.sample_s1   (sample_s1),
		.advance     (advance),
		.out_valid_q (m_tvalid),
		.out_ready   (m_tready),
		.key_code_q  (key_code),
		.is_hold_q   (m_tuser)
	);

	assign m_tdata = {{(keydb_pkg::TdataW - keydb_pkg::KeyW){1'b0}}, key_code};

endmodule
`default_nettype wire

[src/keydb_checker.sv]
// Port-level checker for the key debounce and hold detect block, with its bind.
`default_nettype none
module keydb_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tvalid,
	input wire logic                            s_tready,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [keydb_pkg::TdataW-1:0]    m_tdata,
	input wire logic                            m_tuser
);

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result item dropped while stalled");

	// Input side only backs up when both stages are full and the output stalls
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without output backpressure");

	// A hold message always names its keys
	a_hold_keys: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata[1:0] != 2'b00))
		else $error("hold item without keys");

	// Padding bits of the result stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[keydb_pkg::TdataW-1:keydb_pkg::KeyW] == '0))
		else $error("result padding not zero");

	// An accepted sample taken with no result pending must yield a result once the output is ready for it
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid ##1 m_tready |=> m_tvalid)
		else $error("result item missing after accepted sample");

endmodule

bind key_debounce_hold_detect keydb_checker u_keydb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
